/* rtl/orf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_pkg
// Shared types and constants of the overwriting ring FIFO.
// ----------------------------------------------------------------------------
package orf_pkg;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // beat taken, result registers update
        logic push;    // store value at write pointer
        logic drop;    // advance read pointer over the oldest entry
        logic reject;  // enqueue refused, capacity zero
        logic pop;     // read oldest entry
        logic empty;   // dequeue found nothing
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic at_cap;
        logic cap_zero;
    } stat_t;

endpackage

/* rtl/orf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_in_if
// Input channel: one enqueue or dequeue request per beat.
// ----------------------------------------------------------------------------
interface orf_in_if #(
    parameter int DATA_WIDTH = orf_pkg::DEF_DATA_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [DATA_WIDTH-1:0] value_in;

    modport source (output valid, output action, output value_in, input ready);
    modport sink   (input valid, input action, input value_in, output ready);
endinterface

/* rtl/orf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_out_if
// Output channel: one result per request.
// ----------------------------------------------------------------------------
interface orf_out_if #(
    parameter int DATA_WIDTH = orf_pkg::DEF_DATA_WIDTH
);
    logic                              valid;
    logic                              ready;
    logic signed [DATA_WIDTH-1:0]      value_out;
    logic                              was_empty;
    logic                              dropped_oldest;
    logic                              rejected;
    logic [orf_pkg::COUNT_W-1:0]       fill_count;

    modport source (output valid, output value_out, output was_empty,
                    output dropped_oldest, output rejected, output fill_count,
                    input ready);
    modport sink   (input valid, input value_out, input was_empty,
                    input dropped_oldest, input rejected, input fill_count,
                    output ready);
endinterface

/* rtl/orf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_ctrl
// Handshake control and per-request decode for the ring FIFO.
// ----------------------------------------------------------------------------
module orf_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_action,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  orf_pkg::stat_t stat,
    output orf_pkg::cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;
    logic is_enq;

    // result register frees up in the same cycle it is taken
    assign in_ready  = (state_reg == ST_IDLE) || out_ready;
    assign out_valid = (state_reg == ST_HOLD);
    assign accept    = in_valid && in_ready;
    assign is_enq    = (in_action == orf_pkg::ACT_ENQ);

    always_comb
    begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.reject = accept && is_enq && stat.cap_zero;
        cmd.push   = accept && is_enq && !stat.cap_zero;
        cmd.drop   = accept && is_enq && !stat.cap_zero && stat.at_cap;
        cmd.pop    = accept && !is_enq && !stat.empty;
        cmd.empty  = accept && !is_enq && stat.empty;
    end

    always_comb
    begin
        priority if (accept)
        begin
            state_next = ST_HOLD;
        end
        else if (out_ready)
        begin
            state_next = ST_IDLE;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/orf_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orf_datapath
// Ring store, pointers, fill count, capacity register and result registers.
// ----------------------------------------------------------------------------
module orf_datapath #(
    parameter int DEPTH      = orf_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = orf_pkg::DEF_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [orf_pkg::CAP_W-1:0]     cfg_data,
    input  logic signed [DATA_WIDTH-1:0]  value_in,
    input  orf_pkg::cmd_t                 cmd,
    output orf_pkg::stat_t                stat,
    output logic signed [DATA_WIDTH-1:0]  value_out,
    output logic                          was_empty,
    output logic                          dropped_oldest,
    output logic                          rejected,
    output logic [orf_pkg::COUNT_W-1:0]   fill_count
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_MAX = (1 << orf_pkg::CAP_W) - 1;
    localparam logic [orf_pkg::CAP_W-1:0] CAP_LIMIT =
        orf_pkg::CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [DATA_WIDTH-1:0]         mem [DEPTH];
    logic [DATA_WIDTH-1:0]         rdata_reg;

    logic [orf_pkg::CAP_W-1:0]     cap_reg;
    logic [orf_pkg::CAP_W-1:0]     cap_eff;
    logic [PTR_W-1:0]              rptr_reg;
    logic [PTR_W-1:0]              rptr_next;
    logic [PTR_W-1:0]              wptr_reg;
    logic [PTR_W-1:0]              wptr_next;
    logic [orf_pkg::COUNT_W-1:0]   count_reg;
    logic [orf_pkg::COUNT_W-1:0]   count_next;

    logic                          popped_reg;
    logic                          was_empty_reg;
    logic                          dropped_reg;
    logic                          rejected_reg;

    assign cap_eff = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;

    assign stat.empty    = (count_reg == '0);
    assign stat.at_cap   = (orf_pkg::CAP_W'(count_reg) >= cap_eff);
    assign stat.cap_zero = (cap_eff == '0);

    assign rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
    assign wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push && !cmd.drop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= orf_pkg::CAP_RESET;
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.push)
            begin
                wptr_reg <= wptr_next;
            end
            if (cmd.drop || cmd.pop)
            begin
                rptr_reg <= rptr_next;
            end
            count_reg <= count_next;
        end
    end

    // ring store
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wptr_reg] <= value_in;
        end
        if (cmd.pop)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    // result flags, held until the next beat is taken
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            popped_reg    <= cmd.pop;
            was_empty_reg <= cmd.empty;
            dropped_reg   <= cmd.drop;
            rejected_reg  <= cmd.reject;
        end
    end

    assign value_out      = popped_reg ? rdata_reg : '0;
    assign was_empty      = was_empty_reg;
    assign dropped_oldest = dropped_reg;
    assign rejected       = rejected_reg;
    assign fill_count     = count_reg;

endmodule

/* rtl/overwriting_ring_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_fifo
// FIFO on a ring store whose capacity is programmable; a full queue
// overwrites its oldest entry on enqueue.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake      Beat contents
//  item     in   valid/ready    action, value_in
//  result   out  valid/ready    value_out, was_empty, dropped_oldest,
//                               rejected, fill_count
//  cfg      in   cfg_we         cfg_data -> capacity
//
//  One request per cycle unless a waiting result stalls; its result appears in the cycle after the beat.
//  The result sits in an output register; a new request is taken in the
//  same cycle the held result is taken.
//  A stall on result holds item off only while a result is waiting.
//  Reset (rst_n low) empties the queue and sets capacity to 16.
// ----------------------------------------------------------------------------
module overwriting_ring_fifo #(
    parameter int DEPTH      = orf_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = orf_pkg::DEF_DATA_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [orf_pkg::CAP_W-1:0] cfg_data,
    orf_in_if.sink                    item,
    orf_out_if.source                 result
);

    orf_pkg::cmd_t  cmd;
    orf_pkg::stat_t stat;

    logic                          in_ready;
    logic                          out_valid;
    logic signed [DATA_WIDTH-1:0]  value_out;
    logic                          was_empty;
    logic                          dropped_oldest;
    logic                          rejected;
    logic [orf_pkg::COUNT_W-1:0]   fill_count;

    orf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_action (item.action),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    orf_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .value_in       (item.value_in),
        .cmd            (cmd),
        .stat           (stat),
        .value_out      (value_out),
        .was_empty      (was_empty),
        .dropped_oldest (dropped_oldest),
        .rejected       (rejected),
        .fill_count     (fill_count)
    );

    assign item.ready            = in_ready;
    assign result.valid          = out_valid;
    assign result.value_out      = value_out;
    assign result.was_empty      = was_empty;
    assign result.dropped_oldest = dropped_oldest;
    assign result.rejected       = rejected;
    assign result.fill_count     = fill_count;

endmodule

/* dv/overwriting_ring_fifo_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_fifo_test
// Self-checking bench for the overwriting ring FIFO. A shadow queue predicts
// every result beat; directed steps cover an empty dequeue, extreme values,
// capacity edge cases and a long result stall, then random phases run over
// several capacities with random gaps and idle-free stretches.
// ----------------------------------------------------------------------------
module overwriting_ring_fifo_test;

    localparam int DW             = orf_pkg::DEF_DATA_WIDTH;
    localparam int PTR_W          = $clog2(orf_pkg::DEF_DEPTH);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 195;

    typedef struct packed {
        logic signed [DW-1:0]        value_out;
        logic                        was_empty;
        logic                        dropped_oldest;
        logic                        rejected;
        logic [orf_pkg::COUNT_W-1:0] fill_count;
    } fifo_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [orf_pkg::CAP_W-1:0] cfg_data;

    orf_in_if  #(.DATA_WIDTH(DW)) item_ch ();
    orf_out_if #(.DATA_WIDTH(DW)) result_ch ();

    overwriting_ring_fifo #(
        .DEPTH      (orf_pkg::DEF_DEPTH),
        .DATA_WIDTH (DW)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .item     (item_ch),
        .result   (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the queue
    logic signed [DW-1:0]        shadow_ring [orf_pkg::DEF_DEPTH];
    logic [PTR_W-1:0]            shadow_rd    = '0;
    logic [PTR_W-1:0]            shadow_wr    = '0;
    logic [orf_pkg::COUNT_W-1:0] shadow_count = '0;
    logic [orf_pkg::CAP_W-1:0]   shadow_cap   = orf_pkg::CAP_RESET;

    fifo_result_t reply_q [$];
    int           fail_count   = 0;
    int           src_max_gap  = 8;
    int           sink_max_gap = 8;
    int           sink_hold    = 0;
    int           quiet_cycles = 0;

    function automatic fifo_result_t shadow_step(input logic act,
                                                 input logic signed [DW-1:0] val);
        fifo_result_t              r;
        logic [orf_pkg::CAP_W-1:0] lim;
        r   = '0;
        lim = (shadow_cap > orf_pkg::CAP_W'(orf_pkg::DEF_DEPTH)) ?
              orf_pkg::CAP_W'(orf_pkg::DEF_DEPTH) : shadow_cap;
        if (act == orf_pkg::ACT_ENQ)
        begin
            if (lim == '0)
                r.rejected = 1'b1;
            else
            begin
                if (shadow_count >= lim)
                begin
                    shadow_rd        = shadow_rd + 1'b1;
                    r.dropped_oldest = 1'b1;
                end
                else
                    shadow_count = shadow_count + 1'b1;
                shadow_ring[shadow_wr] = val;
                shadow_wr              = shadow_wr + 1'b1;
            end
        end
        else if (shadow_count == '0)
            r.was_empty = 1'b1;
        else
        begin
            r.value_out  = shadow_ring[shadow_rd];
            shadow_rd    = shadow_rd + 1'b1;
            shadow_count = shadow_count - 1'b1;
        end
        r.fill_count = shadow_count;
        return r;
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_op(input logic act, input logic signed [DW-1:0] val);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.action   <= act;
        item_ch.value_in <= val;
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
        reply_q.push_back(shadow_step(act, val));
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (reply_q.size() != 0);
    endtask

    task automatic set_capacity(input logic [orf_pkg::CAP_W-1:0] cap);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cap  = cap;
    endtask

    task automatic test_empty_after_reset();
        send_op(orf_pkg::ACT_DEQ, '0);
        wait_idle();
    endtask

    task automatic test_extreme_values();
        send_op(orf_pkg::ACT_ENQ, 32'sh8000_0000);
        send_op(orf_pkg::ACT_ENQ, 32'sh7FFF_FFFF);
        send_op(orf_pkg::ACT_ENQ, 32'shFFFF_FFFF);
        send_op(orf_pkg::ACT_ENQ, 32'sh0000_0000);
        repeat (5) send_op(orf_pkg::ACT_DEQ, $urandom);
        wait_idle();
    endtask

    task automatic test_capacity_edges();
        set_capacity(orf_pkg::CAP_W'(2));
        repeat (3) send_op(orf_pkg::ACT_ENQ, $urandom);
        wait_idle();
        // capacity zero: enqueue refused, dequeues still drain
        set_capacity(orf_pkg::CAP_W'(0));
        send_op(orf_pkg::ACT_ENQ, $urandom);
        repeat (2) send_op(orf_pkg::ACT_DEQ, $urandom);
        wait_idle();
        set_capacity(orf_pkg::CAP_W'(1));
        repeat (2) send_op(orf_pkg::ACT_ENQ, $urandom);
        send_op(orf_pkg::ACT_DEQ, $urandom);
        wait_idle();
        // capacity lowered below the held count
        set_capacity(orf_pkg::CAP_W'(3));
        repeat (3) send_op(orf_pkg::ACT_ENQ, $urandom);
        wait_idle();
        set_capacity(orf_pkg::CAP_W'(1));
        send_op(orf_pkg::ACT_ENQ, $urandom);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_capacity(orf_pkg::CAP_W'(orf_pkg::DEF_DEPTH));
        src_max_gap = 0;
        sink_hold   = 150;
        repeat (40)
            send_op(($urandom_range(0, 99) < 70) ? orf_pkg::ACT_ENQ : orf_pkg::ACT_DEQ,
                    $urandom);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int cap_plan [8];
        int enq_plan [8];
        int cap;
        cap_plan = '{16, 31, 0, 1, 17, 7, 0, 16};
        enq_plan = '{50, 80, 60, 60, 70, 35, 55, 50};
        for (int p = 0; p < 8; p++)
        begin
            cap = (p == 6) ? $urandom_range(0, 31) : cap_plan[p];
            set_capacity(orf_pkg::CAP_W'(cap));
            src_max_gap  = (p % 2 == 1) ? 0 : 8;
            sink_max_gap = (p % 3 == 1) ? 0 : 8;
            repeat (PHASE_ITEMS)
                send_op(($urandom_range(0, 99) < enq_plan[p]) ?
                        orf_pkg::ACT_ENQ : orf_pkg::ACT_DEQ,
                        $urandom);
            wait_idle();
        end
        sink_max_gap = 8;
    endtask

    // result side: random stalls, plus a long hold on request
    initial
    begin : result_sink
        int stall;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                stall     = sink_hold;
                sink_hold = 0;
            end
            else
                stall = $urandom_range(0, sink_max_gap);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    always @(posedge clk)
    begin : reply_check
        fifo_result_t got;
        fifo_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.value_out      = result_ch.value_out;
            got.was_empty      = result_ch.was_empty;
            got.dropped_oldest = result_ch.dropped_oldest;
            got.rejected       = result_ch.rejected;
            got.fill_count     = result_ch.fill_count;
            if (reply_q.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: result beat with nothing pending", $time);
                fail_count++;
            end
            else
            begin
                want = reply_q.pop_front();
                if (got !== want)
                begin
                    if (fail_count < 10)
                        $display("%0t: mismatch exp value=%0d empty=%b drop=%b rej=%b ",
                                 $time, want.value_out, want.was_empty,
                                 want.dropped_oldest, want.rejected,
                                 "fill=%0d, got value=%0d empty=%b drop=%b rej=%b fill=%0d",
                                 want.fill_count,
                                 got.value_out, got.was_empty, got.dropped_oldest,
                                 got.rejected, got.fill_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        item_ch.valid    = 1'b0;
        item_ch.action   = orf_pkg::ACT_ENQ;
        item_ch.value_in = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_after_reset();
        test_extreme_values();
        test_capacity_edges();
        test_backpressure();
        test_random_phases();

        repeat (4) @(posedge clk);
        fail_count += reply_q.size();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/orf_pkg.sv
rtl/orf_in_if.sv
rtl/orf_out_if.sv
rtl/orf_ctrl.sv
rtl/orf_datapath.sv
rtl/overwriting_ring_fifo.sv
dv/overwriting_ring_fifo_test.sv
